[sv/assert_macros.svh]
// Assertion macros for the point projector; all use aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SBPP_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("sbpp check failed");
`define SBPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbpp check failed");
`else
`define SBPP_ASSERT(lbl, expr)
`define SBPP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[sv/sbpp_pkg.sv]
`timescale 1ns / 1ps
package sbpp_pkg;
    localparam int LANES = 3;
    localparam int SQ_CELLS = 32;
    localparam int DV_CELLS = 31;
    localparam logic [30:0] BONE_RESET = 31'd65536;
    localparam logic [61:0] ROUND_HALF = 62'd1 << 29;

    typedef struct packed {
        logic [LANES-1:0][31:0] base;
        logic [LANES-1:0]       neg;
        logic                   deg;
    } pld_t;

    typedef struct packed {
        logic                   v;
        logic [63:0]            sum;
        logic [32:0]            rem;
        logic [31:0]            root;
        logic [LANES-1:0][30:0] mag;
        pld_t                   pld;
    } sq_t;

    typedef struct packed {
        logic                   v;
        logic [31:0]            n;
        logic [LANES-1:0][32:0] rem;
        logic [LANES-1:0][30:0] q;
        pld_t                   pld;
    } dv_t;
endpackage

[sv/single_bone_ik_point_projector.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | target_x/y/z, base_x/y/z
// m_      | out       | m_valid / m_ready  | tip_x/y/z, degenerate
// cfg_    | in        | cfg_we             | cfg_wdata (bone_length)
//
// One item per cycle while the output is not stalled; the pipeline has 5 front stages, 32 square root
// cells, 31 divider cells, a multiply stage and the output register.
// The root chain and the divider chain each resolve one bit per cell.
// Synchronous active-low reset clears the valid chain; bone_length -> 65536.
// A full output register with m_ready low freezes every stage; s_ready drops.
`include "assert_macros.svh"
module single_bone_ik_point_projector
    import sbpp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_base_x,
    input  logic signed [31:0] s_base_y,
    input  logic signed [31:0] s_base_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_tip_x,
    output logic signed [31:0] m_tip_y,
    output logic signed [31:0] m_tip_z,
    output logic               m_degenerate,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata
);
    logic [30:0] bone_reg;
    logic        en;

    logic [LANES-1:0][31:0] tgt_w, base_w;

    logic [4:0]             v_reg;
    pld_t                   s1_pld_reg, s2_pld_reg, s3_pld_reg, s4_pld_reg, s5_pld_reg;
    logic [LANES-1:0][32:0] s1_mag_reg, s2_mag_reg;
    logic [LANES-1:0][32:0] s1_mag_next;
    logic [LANES-1:0]       s1_neg_next;
    logic [32:0]            mx;
    logic [1:0]             rsh_next, rsh_reg;
    logic [4:0]             lsh_next, lsh_reg;
    logic [LANES-1:0][30:0] s3_mag_reg, s4_mag_reg, s5_mag_reg, s3_mag_next;
    logic [LANES-1:0][61:0] s4_sq_reg;
    logic [63:0]            s5_sum_reg;

    sq_t sq_bus [0:SQ_CELLS];
    dv_t dv_bus [0:DV_CELLS];

    logic                   mul_v_reg;
    pld_t                   mul_pld_reg;
    logic [LANES-1:0][31:0] off_reg;
    logic [LANES-1:0][61:0] prod;
    logic [LANES-1:0][61:0] prod_rnd;

    logic                   out_v_reg;
    logic [LANES-1:0][31:0] tip_reg, tip_next;
    logic                   deg_reg;
    logic signed [33:0]     acc;

    assign en      = !out_v_reg || m_ready;
    assign s_ready = en;

    assign tgt_w  = {s_target_z, s_target_y, s_target_x};
    assign base_w = {s_base_z, s_base_y, s_base_x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_reg <= BONE_RESET;
        end else if (cfg_we) begin
            bone_reg <= cfg_wdata;
        end
    end

    // stage 1: differences as sign and magnitude
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [32:0] d;
            d = {tgt_w[i][31], tgt_w[i]} - {base_w[i][31], base_w[i]};
            s1_neg_next[i] = d[32];
            s1_mag_next[i] = d[32] ? 33'(-d) : d;
        end
    end

    // stage 2: block scale amount
    always_comb begin
        mx = s1_mag_reg[0];
        if (s1_mag_reg[1] > mx) mx = s1_mag_reg[1];
        if (s1_mag_reg[2] > mx) mx = s1_mag_reg[2];
        rsh_next = mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
        lsh_next = '0;
        for (int i = 0; i < 31; i++) begin
            if (mx[i]) lsh_next = 5'(30 - i);
        end
    end

    // stage 3: apply scale
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (rsh_reg != 2'd0) begin
                s3_mag_next[i] = 31'(s2_mag_reg[i] >> rsh_reg);
            end else begin
                s3_mag_next[i] = 31'(s2_mag_reg[i] << lsh_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_reg      <= s1_mag_next;
            s1_pld_reg.base <= base_w;
            s1_pld_reg.neg  <= s1_neg_next;
            s1_pld_reg.deg  <= 1'b0;

            s2_mag_reg      <= s1_mag_reg;
            s2_pld_reg.base <= s1_pld_reg.base;
            s2_pld_reg.neg  <= s1_pld_reg.neg;
            s2_pld_reg.deg  <= (mx == '0);
            rsh_reg         <= rsh_next;
            lsh_reg         <= lsh_next;

            s3_mag_reg <= s3_mag_next;
            s3_pld_reg <= s2_pld_reg;

            for (int i = 0; i < LANES; i++) begin
                s4_sq_reg[i] <= 62'(s3_mag_reg[i]) * 62'(s3_mag_reg[i]);
            end
            s4_mag_reg <= s3_mag_reg;
            s4_pld_reg <= s3_pld_reg;

            s5_sum_reg <= 64'(s4_sq_reg[0]) + 64'(s4_sq_reg[1]) + 64'(s4_sq_reg[2]);
            s5_mag_reg <= s4_mag_reg;
            s5_pld_reg <= s4_pld_reg;
        end
    end

    always_comb begin
        sq_bus[0].v    = v_reg[4];
        sq_bus[0].sum  = s5_sum_reg;
        sq_bus[0].rem  = '0;
        sq_bus[0].root = '0;
        sq_bus[0].mag  = s5_mag_reg;
        sq_bus[0].pld  = s5_pld_reg;
    end

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        sbpp_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (sq_bus[g]),
            .d_out   (sq_bus[g+1])
        );
    end

    always_comb begin
        dv_bus[0].v   = sq_bus[SQ_CELLS].v;
        dv_bus[0].n   = sq_bus[SQ_CELLS].root;
        dv_bus[0].q   = '0;
        dv_bus[0].pld = sq_bus[SQ_CELLS].pld;
        for (int i = 0; i < LANES; i++) begin
            dv_bus[0].rem[i] = {2'b00, sq_bus[SQ_CELLS].mag[i]};
        end
    end

    for (genvar g = 0; g < DV_CELLS; g++) begin : g_dv
        sbpp_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (dv_bus[g]),
            .d_out   (dv_bus[g+1])
        );
    end

    // offset = round(u * bone_length / 2^30)
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            prod[i]     = 62'(dv_bus[DV_CELLS].q[i]) * 62'(bone_reg);
            prod_rnd[i] = prod[i] + ROUND_HALF;
        end
    end

    // tip = base +/- offset, saturated; tip = base when degenerate
    always_comb begin
        acc = '0;
        for (int i = 0; i < LANES; i++) begin
            if (mul_pld_reg.neg[i]) begin
                acc = 34'(signed'(mul_pld_reg.base[i])) - signed'({2'b00, off_reg[i]});
            end else begin
                acc = 34'(signed'(mul_pld_reg.base[i])) + signed'({2'b00, off_reg[i]});
            end
            if (mul_pld_reg.deg) begin
                tip_next[i] = mul_pld_reg.base[i];
            end else if (acc > 34'sh7FFFFFFF) begin
                tip_next[i] = 32'h7FFFFFFF;
            end else if (acc < -34'sh80000000) begin
                tip_next[i] = 32'h80000000;
            end else begin
                tip_next[i] = acc[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            mul_v_reg <= dv_bus[DV_CELLS].v;
            out_v_reg <= mul_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_pld_reg <= dv_bus[DV_CELLS].pld;
            for (int i = 0; i < LANES; i++) begin
                off_reg[i] <= prod_rnd[i][61:30];
            end
            tip_reg <= tip_next;
            deg_reg <= mul_pld_reg.deg;
        end
    end

    assign m_valid      = out_v_reg;
    assign m_tip_x      = tip_reg[0];
    assign m_tip_y      = tip_reg[1];
    assign m_tip_z      = tip_reg[2];
    assign m_degenerate = deg_reg;

    `SBPP_ASSERT_IMP(a_root_range, sq_bus[SQ_CELLS].v && !sq_bus[SQ_CELLS].pld.deg,
        sq_bus[SQ_CELLS].root[31:30] != 2'b00)
    `SBPP_ASSERT_IMP(a_unit_range, dv_bus[DV_CELLS].v && !dv_bus[DV_CELLS].pld.deg,
        dv_bus[DV_CELLS].q[0] <= 31'h40000000 && dv_bus[DV_CELLS].q[1] <= 31'h40000000
        && dv_bus[DV_CELLS].q[2] <= 31'h40000000)
    `SBPP_ASSERT_IMP(a_scaled_top, v_reg[2] && !s3_pld_reg.deg,
        s3_mag_reg[0][30] || s3_mag_reg[1][30] || s3_mag_reg[2][30])
endmodule

[sv/sbpp_sqrt_cell.sv]
`timescale 1ns / 1ps
module sbpp_sqrt_cell
    import sbpp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  sq_t  d_in,
    output sq_t  d_out
);
    sq_t         d_reg;
    sq_t         d_next;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    // one root bit per cell
    always_comb begin
        rem_sh = {d_in.rem, d_in.sum[63:62]};
        trial  = {1'b0, d_in.root, 2'b01};
        ge     = rem_sh >= trial;
        d_next = d_in;
        d_next.sum  = {d_in.sum[61:0], 2'b00};
        d_next.rem  = ge ? 33'(rem_sh - trial) : rem_sh[32:0];
        d_next.root = {d_in.root[30:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.v <= 1'b0;
        end else if (en) begin
            d_reg.v <= d_next.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.sum  <= d_next.sum;
            d_reg.rem  <= d_next.rem;
            d_reg.root <= d_next.root;
            d_reg.mag  <= d_next.mag;
            d_reg.pld  <= d_next.pld;
        end
    end

    assign d_out = d_reg;
endmodule

[sv/sbpp_div_cell.sv]
`timescale 1ns / 1ps
module sbpp_div_cell
    import sbpp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic en,
    input  dv_t  d_in,
    output dv_t  d_out
);
    dv_t         d_reg;
    dv_t         d_next;
    logic [32:0] diff;
    logic        ge;

    // one quotient bit per lane per cell
    always_comb begin
        d_next = d_in;
        diff   = '0;
        ge     = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            ge   = d_in.rem[i] >= {1'b0, d_in.n};
            diff = ge ? 33'(d_in.rem[i] - {1'b0, d_in.n}) : d_in.rem[i];
            d_next.rem[i] = {diff[31:0], 1'b0};
            d_next.q[i]   = {d_in.q[i][29:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.v <= 1'b0;
        end else if (en) begin
            d_reg.v <= d_next.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.n   <= d_next.n;
            d_reg.rem <= d_next.rem;
            d_reg.q   <= d_next.q;
            d_reg.pld <= d_next.pld;
        end
    end

    assign d_out = d_reg;
endmodule
